### rtl/core/ccorr_pkg.sv
// Shared types and constants for the cross-correlation engine.
// Holds operation codes, register indexes, field widths and the
// controller/datapath command and status structs. No dependencies.
package ccorr_pkg;

   localparam int OP_W       = 2;
   localparam int INDEX_W    = 11;
   localparam int LEN_W      = 11;
   localparam int COUNT_W    = 11;
   localparam int SUM_W      = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [OP_W-1:0] OP_WRITE_H = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_X = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LEN_H = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_X = 2'd1;

   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -48'sh8000_0000_0000;

   typedef struct packed {
      logic write_h;
      logic write_x;
      logic capture;
      logic setup;
      logic step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic lag_error;
      logic last_step;
      logic pipe_empty;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/ccorr_if.sv
// Valid/ready channel interfaces of the cross-correlation engine:
// request, response and register write channels.
// Depends on ccorr_pkg for field widths.
interface ccorr_req_if import ccorr_pkg::*; #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [INDEX_W-1:0]     index;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output operation, output index, output sample,
                   input ready);
   modport sink   (input valid, input operation, input index, input sample,
                   output ready);
endinterface

interface ccorr_rsp_if import ccorr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SUM_W-1:0]   sum;
   logic [COUNT_W-1:0] lag_count;
   logic               lag_error;

   modport source (output valid, output sum, output lag_count, output lag_error,
                   input ready);
   modport sink   (input valid, input sum, input lag_count, input lag_error,
                   output ready);
endinterface

interface ccorr_csr_if import ccorr_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/ccorr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ccorr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ccorr_ctrl.sv
// Sequencing state machine of the cross-correlation engine.
// Depends on ccorr_pkg for operation codes and the command/status structs.
module ccorr_ctrl import ccorr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_operation,
   output logic            req_ready,
   input  dp_status_type   status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  OP_WRITE_H: cmd.write_h = 1'b1;
                  OP_WRITE_X: cmd.write_x = 1'b1;
                  OP_QUERY: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_SETUP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (status.lag_error) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               if (status.last_step) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An out-of-range lag skips the multiply-accumulate walk entirely.
   a_error_skips_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && status.lag_error |=> (state_ff == ST_DONE))
      else $error("out-of-range lag did not go straight to the result");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

   a_query_starts_setup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && req_valid && (req_operation == OP_QUERY)
      |=> (state_ff == ST_SETUP))
      else $error("accepted query did not start the lag setup");

endmodule

### rtl/core/ccorr_datapath.sv
// Datapath of the cross-correlation engine: sample memories, lag bounds,
// address walk, multiply-accumulate pipeline and output register.
// Depends on ccorr_pkg and ccorr_ram.
module ccorr_datapath import ccorr_pkg::*; #(
   parameter int MAX_LEN     = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [LEN_W-1:0]       len_h_cfg,
   input  logic [LEN_W-1:0]       len_x_cfg,
   input  logic [INDEX_W-1:0]     req_index,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [SUM_W-1:0]       rsp_sum,
   output logic [COUNT_W-1:0]     rsp_lag_count,
   output logic                   rsp_lag_error
);

   localparam int AW     = $clog2(MAX_LEN);
   localparam int LW     = $clog2(MAX_LEN + 1);
   localparam int LGW    = LW + 1;
   localparam int IW     = ((LW > INDEX_W) ? LW : INDEX_W) + 2;
   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + AW + 1;
   localparam int EXT_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;

   // Effective lengths: zero counts as one, anything above the store size is clamped.
   logic [LW-1:0]  lh, lx;
   logic [LGW-1:0] lags;

   always_comb begin
      if (len_h_cfg == '0) begin
         lh = LW'(1);
      end else if (32'(len_h_cfg) > MAX_LEN) begin
         lh = LW'(MAX_LEN);
      end else begin
         lh = LW'(len_h_cfg);
      end
      if (len_x_cfg == '0) begin
         lx = LW'(1);
      end else if (32'(len_x_cfg) > MAX_LEN) begin
         lx = LW'(MAX_LEN);
      end else begin
         lx = LW'(len_x_cfg);
      end
      lags = LGW'(lh) + LGW'(lx) - LGW'(1);
   end

   // Lag bounds for the walk.
   logic [INDEX_W-1:0] lag_ff;
   logic [IW-1:0]      lag_p1, lh_w, lx_w, j0_w, k0_w, j1_w, n_w;
   logic               err_w;

   always_comb begin
      lag_p1 = IW'(lag_ff) + IW'(1);
      lh_w   = IW'(lh);
      lx_w   = IW'(lx);
      if (lag_p1 >= lh_w) begin
         j0_w = lag_p1 - lh_w;
         k0_w = '0;
      end else begin
         j0_w = '0;
         k0_w = lh_w - lag_p1;
      end
      j1_w  = (lag_p1 < lx_w) ? lag_p1 : lx_w;
      n_w   = j1_w - j0_w;
      err_w = IW'(lag_ff) >= IW'(lags);
   end

   logic [AW-1:0] j_ff, k_ff;
   logic [LW-1:0] cnt_ff;
   logic          err_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lag_ff <= req_index;
      end
      if (cmd.setup) begin
         j_ff <= AW'(j0_w);
         k_ff <= AW'(k0_w);
      end else if (cmd.step) begin
         j_ff <= j_ff + AW'(1);
         k_ff <= k_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         err_ff <= 1'b0;
      end else if (cmd.setup) begin
         cnt_ff <= LW'(n_w);
         err_ff <= err_w;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff - LW'(1);
      end
   end

   // Sample stores. Writes beyond the store size are dropped.
   logic                   wr_in_range;
   logic [SAMPLE_BITS-1:0] h_rd, x_rd;

   assign wr_in_range = 32'(req_index) < MAX_LEN;

   ccorr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_h_ram (
      .clock   (clock),
      .wr_en   (cmd.write_h && wr_in_range),
      .wr_addr (AW'(req_index)),
      .wr_data (req_sample),
      .rd_en   (cmd.step),
      .rd_addr (k_ff),
      .rd_data (h_rd)
   );

   ccorr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_x_ram (
      .clock   (clock),
      .wr_en   (cmd.write_x && wr_in_range),
      .wr_addr (AW'(req_index)),
      .wr_data (req_sample),
      .rd_en   (cmd.step),
      .rd_addr (j_ff),
      .rd_data (x_rd)
   );

   // Multiply-accumulate pipeline: read, multiply, accumulate.
   logic                     rd_valid_ff, prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [EXT_W-1:0]  acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.step;
         prod_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prod_ff <= $signed(h_rd) * $signed(x_rd);
      end
      if (cmd.setup) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + EXT_W'(prod_ff);
      end
   end

   logic signed [SUM_W-1:0] sat_sum;

   always_comb begin
      if (acc_ff > EXT_W'(SUM_MAX)) begin
         sat_sum = SUM_MAX;
      end else if (acc_ff < EXT_W'(SUM_MIN)) begin
         sat_sum = SUM_MIN;
      end else begin
         sat_sum = SUM_W'(acc_ff);
      end
   end

   // Output register.
   logic               rsp_valid_ff;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic [COUNT_W-1:0] rsp_lag_count_ff;
   logic               rsp_lag_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_sum_ff       <= err_ff ? '0 : sat_sum;
         rsp_lag_count_ff <= COUNT_W'(lags);
         rsp_lag_error_ff <= err_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum       = rsp_sum_ff;
   assign rsp_lag_count = rsp_lag_count_ff;
   assign rsp_lag_error = rsp_lag_error_ff;

   assign status.lag_error  = err_ff;
   assign status.last_step  = (cnt_ff == LW'(1));
   assign status.pipe_empty = !rd_valid_ff && !prod_valid_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   a_load_needs_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a beat not yet taken");

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && !err_ff |-> !rd_valid_ff && !prod_valid_ff)
      else $error("result loaded with products still in flight");

   a_step_has_pairs: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (cnt_ff != '0))
      else $error("walk stepped past its last sample pair");

endmodule

### rtl/core/cross_correlation_engine.sv
// Full cross-correlation engine: top level with register file, controller and datapath.
// Query: after acceptance the engine sets up the lag bounds for lag i, walks the n
// overlapping sample pairs (n = 1..min(len_h,len_x)), drains the pipeline and loads the
// output register; an out-of-range lag skips the walk. One multiply-accumulate per cycle.
// Throughput: one write per cycle while idle; a query must finish before the next request
// is taken and waits for the output register while the response side stalls; one item at a time.
// Reset (synchronous, active high) clears control state and sets both lengths to 1024;
// the sample memories are not cleared and hold undefined data until written.
module cross_correlation_engine import ccorr_pkg::*; #(
   parameter int MAX_LEN     = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ccorr_req_if.sink   req_if,
   ccorr_rsp_if.source rsp_if,
   ccorr_csr_if.sink   csr_if
);

   // Length registers. The write channel never stalls; the block only expects
   // writes while it is idle, so no interlock with a running query is needed.
   logic [LEN_W-1:0] len_h_ff, len_h_in;
   logic [LEN_W-1:0] len_x_ff, len_x_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      len_h_in = len_h_ff;
      len_x_in = len_x_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_LEN_H: len_h_in = LEN_W'(csr_if.data);
            CSR_LEN_X: len_x_in = LEN_W'(csr_if.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_h_ff <= LEN_RESET;
         len_x_ff <= LEN_RESET;
      end else begin
         len_h_ff <= len_h_in;
         len_x_ff <= len_x_in;
      end
   end

   // The controller takes a request beat only when idle. Sample writes go
   // straight to the memories in the accept cycle; a query walks the
   // overlapping pairs, one pair per cycle, through the datapath pipeline.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   ccorr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_operation (req_if.operation),
      .req_ready     (req_if.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath holds the result in an output register, so the next
   // request is taken while a finished result still waits on the response side.
   ccorr_datapath #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .len_h_cfg     (len_h_ff),
      .len_x_cfg     (len_x_ff),
      .req_index     (req_if.index),
      .req_sample    (SAMPLE_BITS'(req_if.sample)),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_sum       (rsp_if.sum),
      .rsp_lag_count (rsp_if.lag_count),
      .rsp_lag_error (rsp_if.lag_error)
   );

endmodule
